>>> src/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define SPS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define SPS_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SPS_ASSERT(label, clk, rst, prop, msg)
`define SPS_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

>>> src/sps_pkg.sv
// Types, constants and coil tables of the stepper position sequencer.
package sps_pkg;

  localparam int OPCODE_W    = 2;
  localparam int OPERAND_W   = 32;
  localparam int COIL_W      = 4;
  localparam int POS_OUT_W   = 32;
  localparam int CFG_INDEX_W = 2;

  localparam int               PERIOD_RESET = 10000;
  localparam logic [COIL_W-1:0] COIL_RESET  = 4'hF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK     = 2'd0,
    OP_SET_DEST = 2'd1,
    OP_STEP_REL = 2'd2,
    OP_REDEFINE = 2'd3
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BIPOLAR     = 2'd0,
    REG_HALF_STEP   = 2'd1,
    REG_STEP_PERIOD = 2'd2
  } cfg_reg_t;

  localparam logic [COIL_W-1:0] UNI_FULL [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
  localparam logic [COIL_W-1:0] UNI_HALF [8] =
    '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
  localparam logic [COIL_W-1:0] BI_FULL  [4] = '{4'h5, 4'h6, 4'hA, 4'h9};
  localparam logic [COIL_W-1:0] BI_HALF  [8] =
    '{4'h1, 4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9};

  // Pick the coil pattern for a phase: full step uses two phase bits, half step three.
  function automatic logic [COIL_W-1:0] coil_pattern(input logic       bipolar,
                                                     input logic       half_step,
                                                     input logic [2:0] phase);
    logic [COIL_W-1:0] pattern;
    if (bipolar) begin
      pattern = half_step ? BI_HALF[phase] : BI_FULL[phase[1:0]];
    end else begin
      pattern = half_step ? UNI_HALF[phase] : UNI_FULL[phase[1:0]];
    end
    return pattern;
  endfunction

endpackage

>>> src/sps_cmd_if.sv
// Command channel: opcode and operand with valid/ready handshake.
interface sps_cmd_if;
  logic                                      valid;
  logic                                      ready;
  logic [sps_pkg::OPCODE_W-1:0]              opcode;
  logic signed [sps_pkg::OPERAND_W-1:0]      operand_value;

  modport source (output valid, output opcode, output operand_value, input ready);
  modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

>>> src/sps_result_if.sv
// Result channel: coil drive, positions and status with valid/ready handshake.
interface sps_result_if;
  logic                                  valid;
  logic                                  ready;
  logic [sps_pkg::COIL_W-1:0]            coil_drive;
  logic signed [sps_pkg::POS_OUT_W-1:0]  current_position;
  logic signed [sps_pkg::POS_OUT_W-1:0]  target_position;
  logic                                  moving;
  logic                                  step_taken;

  modport source (output valid, output coil_drive, output current_position,
                  output target_position, output moving, output step_taken,
                  input ready);
  modport sink   (input valid, input coil_drive, input current_position,
                  input target_position, input moving, input step_taken,
                  output ready);
endinterface

>>> src/stepper_position_sequencer_unit.sv
// Stepper position sequencer: command decode, step timer and coil phase output.
//
// Usage:
//   cmd carries one transaction per command or microsecond tick: opcode 0 is a
//   tick, 1 sets the destination, 2 steps relative to the current position,
//   3 redefines the current position. result returns exactly one transaction
//   per command with the coil drive, both positions and the timer status.
//   The cfg port writes the mode bits and the step period; write it only while
//   no command is in flight.
// Timing and throughput: a result is registered and appears in the cycle after
//   its command is taken, and one command is taken every cycle while no result
//   is held by the receiver. The whole update of position, destination, period
//   counter and coil phase fits between the command edge and the result register.
// Reset: position and destination clear, the timer stops, all coils turn on,
//   bipolar full-step mode with a period of 10000 ticks.
// Stall: a result held by the receiver stays in the output register; cmd.ready
//   drops until that result is taken, and rises again in the cycle it leaves.
`include "assert_macros.svh"

module stepper_position_sequencer_unit #(
  parameter int POSITION_BITS = 32,
  parameter int PERIOD_BITS   = 26
) (
  input  logic                              clk,
  input  logic                              rst,
  sps_cmd_if.sink                           cmd,
  sps_result_if.source                      result,
  input  logic                              cfg_wr_en,
  input  logic [sps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [PERIOD_BITS-1:0]            cfg_data
);
  import sps_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  // Configuration
  logic                     bipolar_mode;
  logic                     half_step_mode;
  logic [PERIOD_BITS-1:0]   step_period;

  // Motion state
  logic [POSITION_BITS-1:0] position;
  logic [POSITION_BITS-1:0] destination;
  logic                     running;
  logic [PERIOD_BITS-1:0]   period_count;
  logic [COIL_W-1:0]        coil;

  logic [POSITION_BITS-1:0] position_next;
  logic [POSITION_BITS-1:0] destination_next;
  logic                     running_next;
  logic [PERIOD_BITS-1:0]   period_count_next;
  logic [COIL_W-1:0]        coil_next;
  logic                     step_next;

  logic                     out_valid;
  logic                     accept;

  logic [POSITION_BITS-1:0] operand;
  logic [POSITION_BITS-1:0] gap;
  logic [POSITION_BITS-1:0] step_pos;
  logic [PERIOD_BITS-1:0]   count_inc;
  logic                     pos_below;
  logic                     pos_above;
  logic                     reached;
  logic                     expire;
  logic                     differ;
  logic                     run_cmd;
  logic                     cfg_differ;

  assign cmd.ready    = !out_valid || result.ready;
  assign accept       = cmd.valid && cmd.ready;
  assign result.valid = out_valid;

  always_comb begin
    operand    = POSITION_BITS'(cmd.operand_value);
    gap        = destination - position;
    pos_below  = $signed(position) < $signed(destination);
    pos_above  = $signed(destination) < $signed(position);
    count_inc  = period_count + PERIOD_BITS'(1);
    expire     = count_inc >= step_period;
    cfg_differ = position != destination;

    // Step one position toward the destination; the step lands on it when
    // the distance is exactly one in the direction of travel.
    if (pos_below) begin
      step_pos = position + POS_ONE;
      reached  = gap == POS_ONE;
    end else if (pos_above) begin
      step_pos = position - POS_ONE;
      reached  = gap == '1;
    end else begin
      step_pos = position;
      reached  = 1'b1;
    end

    position_next     = position;
    destination_next  = destination;
    running_next      = running;
    period_count_next = period_count;
    coil_next         = coil;
    step_next         = 1'b0;
    differ            = 1'b0;

    unique case (opcode_t'(cmd.opcode))
      OP_TICK: begin
        if (running) begin
          if (expire) begin
            period_count_next = '0;
            step_next         = 1'b1;
            position_next     = step_pos;
            coil_next         = coil_pattern(bipolar_mode, half_step_mode, step_pos[2:0]);
            running_next      = !reached;
          end else begin
            period_count_next = count_inc;
          end
        end
      end
      OP_SET_DEST: begin
        destination_next = operand;
        differ           = operand != position;
      end
      OP_STEP_REL: begin
        destination_next = position + operand;
        differ           = operand != '0;
      end
      OP_REDEFINE: begin
        position_next    = operand;
        destination_next = operand;
        differ           = 1'b0;
      end
      default: begin
      end
    endcase

    // Start or stop the timer after a command; a fresh start clears the count.
    run_cmd = differ && (step_period != '0);
    if (opcode_t'(cmd.opcode) != OP_TICK) begin
      running_next = run_cmd;
      if (!running && run_cmd) begin
        period_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bipolar_mode   <= 1'b1;
      half_step_mode <= 1'b0;
      step_period    <= PERIOD_BITS'(PERIOD_RESET);
      position       <= '0;
      destination    <= '0;
      running        <= 1'b0;
      period_count   <= '0;
      coil           <= COIL_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_BIPOLAR:   bipolar_mode   <= cfg_data[0];
          REG_HALF_STEP: half_step_mode <= cfg_data[0];
          REG_STEP_PERIOD: begin
            step_period  <= cfg_data;
            period_count <= '0;
            running      <= cfg_differ && (cfg_data != '0);
          end
          default: begin
          end
        endcase
      end else if (accept) begin
        position     <= position_next;
        destination  <= destination_next;
        running      <= running_next;
        period_count <= period_count_next;
        coil         <= coil_next;
      end

      if (accept) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on each accepted command, hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      result.coil_drive       <= coil_next;
      result.current_position <= $signed(POS_OUT_W'(position_next));
      result.target_position  <= $signed(POS_OUT_W'(destination_next));
      result.moving           <= running_next;
      result.step_taken       <= step_next;
    end
  end

  `SPS_ASSERT_NEVER(a_run_at_dest, clk, rst, running && (position == destination), "timer runs at destination")
  `SPS_ASSERT_NEVER(a_run_zero_period, clk, rst, running && (step_period == '0), "timer runs with zero period")
  `SPS_ASSERT(a_count_below_period, clk, rst, running |-> (period_count < step_period), "period count reached period")
  `SPS_ASSERT(a_accept_gives_result, clk, rst, accept |=> out_valid, "accepted command gave no result")

endmodule
